FILE: rtl/ecsp_pkg.sv
// ----------------------------------------------------------------------------
// ecsp_pkg
// Shared types and constants of the escape command stream parser.
// ----------------------------------------------------------------------------
package ecsp_pkg;

	// Chunking: a chunk closes after this many items
	localparam int unsigned CHUNK_ITEMS = 10;
	localparam int unsigned CHUNK_CNT_W = $clog2(CHUNK_ITEMS + 1);

	// Stream byte codes
	localparam logic [7:0] BYTE_ESC     = 8'h1b;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_LBRACK  = 8'h5b;  // '['
	localparam logic [7:0] BYTE_RBRACK  = 8'h5d;  // ']'
	localparam logic [7:0] LETTER_A     = 8'h41;  // 'A'
	localparam logic [7:0] LETTER_N     = 8'h4e;  // 'N'
	localparam logic [7:0] LETTER_LOW_I = 8'h69;  // 'i'
	localparam logic [7:0] LETTER_I     = 8'h49;  // 'I'

	// Flag word bits
	localparam int unsigned FLAG_A_BRACKETS = 5;  // 0x20
	localparam int unsigned FLAG_A_DOUBLE   = 6;  // 0x40

	// Node kinds
	localparam logic KIND_CONTROL = 1'b0;
	localparam logic KIND_CHAR    = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LETTER,
		PH_LENGTH,
		PH_ARGS
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  code;
		logic [31:0] arg;
		logic [7:0]  high_byte;
		logic [3:0]  mode_bits;
		logic        notify;
		logic        start;
	} node_t;

endpackage

FILE: rtl/ecsp_in_stage.sv
// ----------------------------------------------------------------------------
// ecsp_in_stage
// Input register: captures one stream byte per transfer.
// ----------------------------------------------------------------------------
module ecsp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       byte_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// Hold while a registered byte waits for the parser
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

FILE: rtl/ecsp_parser.sv
// ----------------------------------------------------------------------------
// ecsp_parser
// Parser state and the one-byte step: builds a node and updates state.
// ----------------------------------------------------------------------------
module ecsp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         byte_s1,
	output logic               res_valid,
	output ecsp_pkg::node_t    res
);

	ecsp_pkg::phase_t                     phase_q, phase_d;
	logic [7:0]                           letter_q, letter_d;
	logic [2:0]                           len_q, len_d;
	logic [1:0]                           idx_q, idx_d;
	logic [31:0]                          accum_q, accum_d;
	logic [7:0]                           high_q, high_d;
	logic [3:0]                           mode_q, mode_d;
	logic                                 pend_q, pend_d;
	logic [ecsp_pkg::CHUNK_CNT_W-1:0]     cnt_q, cnt_d;
	logic                                 space_q, space_d;
	logic [15:0]                          flag_a_q, flag_a_d;
	logic [15:0]                          flag_n_q, flag_n_d;

	logic is_space, full, start, brackets, last_arg;
	logic [31:0] acc_n;
	logic [7:0]  high_n;
	logic [3:0]  mode_n;

	assign is_space = (byte_s1 == ecsp_pkg::BYTE_SPACE);
	assign full     = (cnt_q >= ecsp_pkg::CHUNK_CNT_W'(ecsp_pkg::CHUNK_ITEMS));
	assign start    = (cnt_q == '0) || (is_space ? full : (space_q || full));
	assign brackets = flag_a_q[ecsp_pkg::FLAG_A_BRACKETS] && (flag_n_q[1:0] == 2'b00);
	assign last_arg = ({1'b0, idx_q} + 3'd1) >= len_q;

	// Argument byte folded into the accumulators
	always_comb begin
		acc_n  = accum_q;
		high_n = high_q;
		mode_n = mode_q;
		if (len_q == 3'd3) begin
			unique case (idx_q)
				2'd0:    mode_n = byte_s1[3:0];
				2'd1:    acc_n  = {24'd0, byte_s1};
				default: high_n = byte_s1;
			endcase
		end else if (len_q == 3'd2 && idx_q == 2'd1) begin
			high_n = byte_s1;
		end else begin
			acc_n = accum_q | ({24'd0, byte_s1} << {idx_q, 3'b000});
		end
	end

	always_comb begin
		phase_d  = phase_q;
		letter_d = letter_q;
		len_d    = len_q;
		idx_d    = idx_q;
		accum_d  = accum_q;
		high_d   = high_q;
		mode_d   = mode_q;
		pend_d   = pend_q;
		cnt_d    = cnt_q;
		space_d  = space_q;
		flag_a_d = flag_a_q;
		flag_n_d = flag_n_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = ecsp_pkg::KIND_CONTROL;
		res.code  = letter_q;
		res.start = pend_q;

		unique case (phase_q)
			ecsp_pkg::PH_LETTER: begin
				letter_d = byte_s1;
				phase_d  = ecsp_pkg::PH_LENGTH;
			end
			ecsp_pkg::PH_LENGTH: begin
				idx_d   = '0;
				accum_d = '0;
				high_d  = '0;
				mode_d  = '0;
				len_d   = byte_s1[2:0];
				if (byte_s1 >= 8'd1 && byte_s1 <= 8'd4) begin
					phase_d = ecsp_pkg::PH_ARGS;
				end else begin
					// Out-of-range length: emit at once with zero arguments
					res_valid = 1'b1;
					phase_d   = ecsp_pkg::PH_IDLE;
				end
			end
			ecsp_pkg::PH_ARGS: begin
				accum_d = acc_n;
				high_d  = high_n;
				mode_d  = mode_n;
				idx_d   = idx_q + 2'd1;
				if (last_arg) begin
					res_valid = 1'b1;
					phase_d   = ecsp_pkg::PH_IDLE;
					unique case (len_q)
						3'd1: begin
							res.arg    = {24'd0, acc_n[7:0]};
							res.notify = (letter_q == ecsp_pkg::LETTER_LOW_I);
						end
						3'd2: begin
							res.arg       = {24'd0, acc_n[7:0]};
							res.high_byte = high_n;
							if (letter_q == ecsp_pkg::LETTER_A) flag_a_d = {high_n, acc_n[7:0]};
							if (letter_q == ecsp_pkg::LETTER_N) flag_n_d = {high_n, acc_n[7:0]};
						end
						3'd3: begin
							res.arg       = {24'd0, acc_n[7:0]};
							res.high_byte = high_n;
							res.mode_bits = mode_n;
						end
						default: begin
							res.arg    = acc_n;
							res.notify = (letter_q == ecsp_pkg::LETTER_LOW_I);
						end
					endcase
				end
			end
			default: begin
				cnt_d   = (start ? '0 : cnt_q) + 1'b1;
				space_d = is_space || (!start && space_q);
				if (byte_s1 == ecsp_pkg::BYTE_ESC) begin
					pend_d  = start;
					phase_d = ecsp_pkg::PH_LETTER;
				end else begin
					res_valid = 1'b1;
					res.start = start;
					if (byte_s1 == ecsp_pkg::BYTE_LBRACK && brackets) begin
						res.code = ecsp_pkg::LETTER_I;
						res.arg  = flag_a_q[ecsp_pkg::FLAG_A_DOUBLE] ? 32'd2 : 32'd1;
					end else if (byte_s1 == ecsp_pkg::BYTE_RBRACK && brackets) begin
						res.code = ecsp_pkg::LETTER_I;
					end else begin
						res.kind = ecsp_pkg::KIND_CHAR;
						res.code = byte_s1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ecsp_pkg::PH_IDLE;
			letter_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			accum_q  <= '0;
			high_q   <= '0;
			mode_q   <= '0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
			space_q  <= 1'b0;
			flag_a_q <= '0;
			flag_n_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			letter_q <= letter_d;
			len_q    <= len_d;
			idx_q    <= idx_d;
			accum_q  <= accum_d;
			high_q   <= high_d;
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			cnt_q    <= cnt_d;
			space_q  <= space_d;
			flag_a_q <= flag_a_d;
			flag_n_q <= flag_n_d;
		end
	end

endmodule

FILE: rtl/ecsp_out_reg.sv
// ----------------------------------------------------------------------------
// ecsp_out_reg
// Result register: holds one node until the downstream side takes it.
// ----------------------------------------------------------------------------
module ecsp_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ecsp_pkg::node_t node_d,
	input  logic            node_stall,
	output logic            can_load,
	output logic            node_valid,
	output ecsp_pkg::node_t node_q
);

	assign can_load = !node_valid || !node_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_valid <= 1'b0;
		end else if (load) begin
			node_valid <= 1'b1;
		end else if (!node_stall) begin
			node_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			node_q <= node_d;
		end
	end

endmodule

FILE: rtl/escape_command_stream_parser_top.sv
// ----------------------------------------------------------------------------
// escape_command_stream_parser_top
// Escape command stream parser: bytes in, character and control nodes out.
// ----------------------------------------------------------------------------
// One byte per transfer enters an input register; the parser step between
// that register and the result register decodes it, so a byte can be taken
// every cycle unless the parser is blocked; a byte passes both registers
// in turn. Plain bytes give character nodes; ESC, letter, length and the
// argument bytes give one control node on the last command byte, and bytes
// that finish no node give no transfer. Brackets become 'I' control nodes
// while flag word A has bit 0x20 set and flag word N has bits 0..1 clear.
// The result register only blocks the parser when it is full, stalled, and
// the waiting byte would produce a node; command bytes that complete nothing
// still advance. Flag words and chunk state clear on reset.
// ----------------------------------------------------------------------------
module escape_command_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	output logic        node_valid,
	input  logic        node_stall,
	output logic        node_kind,
	output logic [7:0]  node_code,
	output logic [31:0] node_arg,
	output logic [7:0]  node_high_byte,
	output logic [3:0]  node_mode_bits,
	output logic        notify_attached,
	output logic        chunk_start
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance;
	logic            res_valid;
	logic            can_load;
	ecsp_pkg::node_t res;
	ecsp_pkg::node_t node_q;

	// Advance the registered byte unless it makes a node with nowhere to go
	assign advance = valid_s1 && (!res_valid || can_load);

	ecsp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.in_byte    (in_byte),
		.advance    (advance),
		.byte_stall (byte_stall),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	ecsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ecsp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && res_valid),
		.node_d     (res),
		.node_stall (node_stall),
		.can_load   (can_load),
		.node_valid (node_valid),
		.node_q     (node_q)
	);

	// Drive the node fields from the result register
	assign node_kind       = node_q.kind;
	assign node_code       = node_q.code;
	assign node_arg        = node_q.arg;
	assign node_high_byte  = node_q.high_byte;
	assign node_mode_bits  = node_q.mode_bits;
	assign notify_attached = node_q.notify;
	assign chunk_start     = node_q.start;

endmodule

FILE: bench/ecsp_checker.sv
// ----------------------------------------------------------------------------
// ecsp_checker
// Watches both channels of the stream parser, predicts each node from the
// accepted bytes and compares every node transfer field by field.
// ----------------------------------------------------------------------------
module ecsp_checker
	import ecsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        node_valid,
	input  logic        node_stall,
	input  logic        node_kind,
	input  logic [7:0]  node_code,
	input  logic [31:0] node_arg,
	input  logic [7:0]  node_high_byte,
	input  logic [3:0]  node_mode_bits,
	input  logic        notify_attached,
	input  logic        chunk_start,
	output int          mismatches,
	output int          nodes_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// Parser state as predicted
	phase_t                 phase;
	logic [7:0]             letter;
	logic [7:0]             arg_len;
	logic [1:0]             arg_idx;
	logic [31:0]            accum;
	logic [7:0]             hi_reg;
	logic [3:0]             mode_reg;
	logic                   chunk_pending;
	logic [CHUNK_CNT_W-1:0] item_count;
	logic                   space_run;
	logic [15:0]            flags_a;
	logic [15:0]            flags_n;

	node_t parsed_nodes[$];
	int    node_count;

	initial begin
		mismatches    = 0;
		nodes_waiting = 0;
		node_count    = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) begin
			$display("[%0t] node %0d: %s", $realtime, node_count, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
		end
	endtask

	// Chunk bookkeeping for the first byte of an item
	task automatic step_chunk(input logic [7:0] c, output logic starts);
		starts = 1'b0;
		if (item_count == 0) begin
			starts = 1'b1;
		end else if (c == BYTE_SPACE) begin
			space_run = 1'b1;
			if (item_count >= CHUNK_ITEMS) starts = 1'b1;
		end else if (space_run || item_count >= CHUNK_ITEMS) begin
			starts = 1'b1;
		end
		if (starts) begin
			item_count = '0;
			space_run  = (c == BYTE_SPACE);
		end
		item_count = item_count + 1'b1;
	endtask

	task automatic finish_command(output node_t n);
		n       = '0;
		n.kind  = KIND_CONTROL;
		n.code  = letter;
		n.start = chunk_pending;
		case (arg_len)
			8'd1: begin
				n.arg    = {24'd0, accum[7:0]};
				n.notify = (letter == LETTER_LOW_I);
			end
			8'd2: begin
				n.arg       = {24'd0, accum[7:0]};
				n.high_byte = hi_reg;
				if (letter == LETTER_A) flags_a = {hi_reg, accum[7:0]};
				if (letter == LETTER_N) flags_n = {hi_reg, accum[7:0]};
			end
			8'd3: begin
				n.arg       = {24'd0, accum[7:0]};
				n.high_byte = hi_reg;
				n.mode_bits = mode_reg;
			end
			8'd4: begin
				n.arg    = accum;
				n.notify = (letter == LETTER_LOW_I);
			end
			default: ;
		endcase
		phase = PH_IDLE;
	endtask

	task automatic parse_byte(input logic [7:0] b, output logic emits, output node_t n);
		logic starts;
		logic brackets;
		emits = 1'b0;
		n     = '0;
		case (phase)
			PH_LETTER: begin
				letter = b;
				phase  = PH_LENGTH;
			end
			PH_LENGTH: begin
				arg_len  = b;
				arg_idx  = '0;
				accum    = '0;
				hi_reg   = '0;
				mode_reg = '0;
				if (b >= 8'd1 && b <= 8'd4) begin
					phase = PH_ARGS;
				end else begin
					finish_command(n);
					emits = 1'b1;
				end
			end
			PH_ARGS: begin
				if (arg_len == 8'd3) begin
					if (arg_idx == 2'd0) mode_reg = b[3:0];
					else if (arg_idx == 2'd1) accum = 32'(b);
					else hi_reg = b;
				end else if (arg_len == 8'd2 && arg_idx == 2'd1) begin
					hi_reg = b;
				end else begin
					accum = accum | (32'(b) << (8 * arg_idx));
				end
				if (int'(arg_idx) + 1 >= int'(arg_len)) begin
					finish_command(n);
					emits = 1'b1;
				end else begin
					arg_idx = arg_idx + 1'b1;
				end
			end
			PH_IDLE: begin
				step_chunk(b, starts);
				if (b == BYTE_ESC) begin
					chunk_pending = starts;
					phase         = PH_LETTER;
				end else begin
					brackets = flags_a[FLAG_A_BRACKETS] && (flags_n[1:0] == 2'b00);
					emits    = 1'b1;
					n.start  = starts;
					if (b == BYTE_LBRACK && brackets) begin
						n.kind = KIND_CONTROL;
						n.code = LETTER_I;
						n.arg  = flags_a[FLAG_A_DOUBLE] ? 32'd2 : 32'd1;
					end else if (b == BYTE_RBRACK && brackets) begin
						n.kind = KIND_CONTROL;
						n.code = LETTER_I;
					end else begin
						n.kind = KIND_CHAR;
						n.code = b;
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		node_t got;
		node_t want;
		logic  emits;
		if (!arst_n) begin
			phase         = PH_IDLE;
			letter        = '0;
			arg_len       = '0;
			arg_idx       = '0;
			accum         = '0;
			hi_reg        = '0;
			mode_reg      = '0;
			chunk_pending = 1'b0;
			item_count    = '0;
			space_run     = 1'b0;
			flags_a       = '0;
			flags_n       = '0;
			parsed_nodes.delete();
		end else begin
			// Compare the outgoing node before adding the byte taken at this edge
			if (node_valid && !node_stall) begin
				got = {node_kind, node_code, node_arg, node_high_byte, node_mode_bits,
					notify_attached, chunk_start};
				if (parsed_nodes.size() == 0) begin
					report_mismatch($sformatf("unexpected node, code 0x%0h", node_code));
				end else begin
					want = parsed_nodes.pop_front();
					check_field("node_kind", 32'(got.kind), 32'(want.kind));
					check_field("node_code", 32'(got.code), 32'(want.code));
					check_field("node_arg", got.arg, want.arg);
					check_field("node_high_byte", 32'(got.high_byte), 32'(want.high_byte));
					check_field("node_mode_bits", 32'(got.mode_bits), 32'(want.mode_bits));
					check_field("notify_attached", 32'(got.notify), 32'(want.notify));
					check_field("chunk_start", 32'(got.start), 32'(want.start));
				end
				node_count++;
			end
			if (byte_valid && !byte_stall) begin
				parse_byte(in_byte, emits, want);
				if (emits) parsed_nodes.push_back(want);
			end
		end
		nodes_waiting = parsed_nodes.size();
	end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the escape command stream parser: directed corner
// cases, then random characters, commands and broken sequences under varying
// idle patterns on both channels; the checker beside the block judges nodes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ecsp_pkg::*;

	localparam int ITEM_TARGET  = 1550;
	localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
	localparam int HOLD_BYTES   = 30;   // bytes offered during the hold-off
	localparam int QUIET_LIMIT  = 1000; // cycles without any transfer
	localparam int SETTLE_CYCLES = 10;  // settle time after the final drain

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  in_byte = '0;
	logic        node_valid;
	logic        node_stall = 1'b0;
	logic        node_kind;
	logic [7:0]  node_code;
	logic [31:0] node_arg;
	logic [7:0]  node_high_byte;
	logic [3:0]  node_mode_bits;
	logic        notify_attached;
	logic        chunk_start;

	int mismatches;
	int nodes_waiting;

	int sender_idle_pct = 35;
	int receiver_idle_pct = 59;
	int bytes_sent = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	escape_command_stream_parser_top DUT (.*);
	ecsp_checker checker_i (.*);

	// Clock: 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off whenever the stimulus asks
	// for one. The hold-off is counted here so the sender keeps offering.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			node_stall <= 1'b1;
			hold_left  <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			node_stall  <= 1'b1;
			hold_left   <= HOLD_CYCLES - 1;
			hold_served <= hold_served + 1;
		end else begin
			node_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Watchdog: give up once nothing has moved on either channel for too long
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (node_valid && !node_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one byte, maybe after some idle cycles, and hold it until the
	// transfer happens. Returns right after the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// ESC, letter, length, then the argument bytes (little-endian from args)
	task automatic send_command(input logic [7:0] letter, input logic [7:0] len,
			input logic [31:0] args);
		int count;
		count = (len >= 8'd1 && len <= 8'd4) ? int'(len) : 0;
		send_byte(BYTE_ESC);
		send_byte(letter);
		send_byte(len);
		for (int i = 0; i < count; i++) send_byte(args[8*i +: 8]);
	endtask

	task automatic send_flags(input logic [7:0] letter, input logic [15:0] value);
		send_command(letter, 8'd2, {16'd0, value});
	endtask

	// Drop valid and wait for every predicted node to come out
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (nodes_waiting != 0) @(posedge clk);
	endtask

	// Plain bytes: spaces and brackets are frequent so chunking and bracket
	// decoding see plenty of traffic
	task automatic random_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) send_byte(BYTE_SPACE);
		else if (pick < 28) send_byte(BYTE_LBRACK);
		else if (pick < 35) send_byte(BYTE_RBRACK);
		else send_byte(8'($urandom_range(255)));
	endtask

	// Well-formed command with random content; flag loads favor settings that
	// turn bracket decoding on
	task automatic random_command();
		logic [7:0]  letter;
		logic [7:0]  len;
		logic [31:0] args;
		args = $urandom;
		case ($urandom_range(5))
			0: letter = LETTER_A;
			1: letter = LETTER_N;
			2: letter = LETTER_LOW_I;
			default: letter = 8'($urandom_range(255));
		endcase
		if ($urandom_range(99) < 90) len = 8'($urandom_range(1, 4));
		else if ($urandom_range(1) == 0) len = 8'd0;
		else len = 8'($urandom_range(5, 255));
		if ((letter == LETTER_A || letter == LETTER_N) && $urandom_range(9) < 7) begin
			len = 8'd2;
		end
		if (letter == LETTER_A && $urandom_range(3) != 0) args[FLAG_A_BRACKETS] = 1'b1;
		if (letter == LETTER_N && $urandom_range(9) < 7) args[1:0] = 2'b00;
		send_command(letter, len, args);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			random_char();
		end else if (pick < 90) begin
			random_command();
		end else if (pick < 95) begin
			// broken sequence: a lone escape swallows the next bytes
			send_byte(BYTE_ESC);
		end else begin
			// truncated command: escape and letter only
			send_byte(BYTE_ESC);
			send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes and chunk boundaries around a space
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(BYTE_SPACE);
		send_byte("a");
		// Lengths outside one to four finish the command at once
		send_command("x", 8'd0, 32'h0);
		send_command("y", 8'hff, 32'h0);
		// Notify hook on 'i' with one and four argument bytes
		send_command(LETTER_LOW_I, 8'd1, 32'h0000007f);
		send_command(LETTER_LOW_I, 8'd4, 32'hffffffff);
		send_command("q", 8'd3, 32'h003412fa);
		send_command("r", 8'd2, 32'h0000beef);
		// Brackets: doubled, masked by flag word N, then single
		send_flags(LETTER_A, 16'h0060);
		send_byte(BYTE_LBRACK);
		send_byte(BYTE_RBRACK);
		send_flags(LETTER_N, 16'h0001);
		send_byte(BYTE_LBRACK);
		send_flags(LETTER_N, 16'h0000);
		send_flags(LETTER_A, 16'hff20);
		send_byte(BYTE_LBRACK);
		send_command(BYTE_ESC, 8'd1, {24'd0, BYTE_ESC});
		// Run past the chunk size without spaces
		for (int i = 0; i < 12; i++) send_byte("z");

		// Random: three idle patterns, each about a third of the bytes
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct    = 35;
					receiver_idle_pct <= 59;
				end
				1: begin
					sender_idle_pct    = 59;
					receiver_idle_pct <= 35;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_idle_pct <= 0;
					// Pause until every node is out, then fill the block
					// against a long receiver hold-off
					wait_drained();
					hold_requests <= hold_requests + 1;
					for (int i = 0; i < HOLD_BYTES; i++) send_byte(8'h61 + 8'(i % 26));
				end
			endcase
			while (bytes_sent < (ITEM_TARGET * (ph + 1)) / 3) random_item();
		end

		// Drain, let the pipeline settle, and give the verdict
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
